// ===== sv/uqfp_pkg.sv =====
package uqfp_pkg;

   typedef enum logic [1:0] {
      KIND_NAME   = 2'd0,
      KIND_VALUE  = 2'd1,
      KIND_VBEGIN = 2'd2,
      KIND_FEND   = 2'd3
   } kind_type;

   // Escape decoder phase: plain text, first hex digit, second digit, second digit after bad first
   typedef enum logic [3:0] {
      ESC_PLAIN  = 4'b0001,
      ESC_HI     = 4'b0010,
      ESC_LO     = 4'b0100,
      ESC_LO_BAD = 4'b1000
   } esc_type;

   localparam logic [7:0] CHR_NUL = 8'h00;
   localparam logic [7:0] CHR_EQ  = 8'h3D;
   localparam logic [7:0] CHR_AMP = 8'h26;
   localparam logic [7:0] CHR_PCT = 8'h25;

   typedef struct packed {
      esc_type    phase;
      logic [3:0] high_nibble;
      logic       in_value;
      logic [7:0] field;
      logic       started;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      phase:       ESC_PLAIN,
      high_nibble: 4'd0,
      in_value:    1'b0,
      field:       8'd0,
      started:     1'b0
   };

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] field_index;
      logic       bad_escape;
      logic [8:0] field_total;
      logic       last;
   } result_type;

   // Bit 4 flags a character that is not a hex digit; bits 3:0 hold the nibble
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      logic [4:0] r;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b0, b[3:0]};
      end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
         r = {1'b0, b[3:0] + 4'd9};
      end else begin
         r = 5'b10000;
      end
      return r;
   endfunction

endpackage

// ===== sv/uqfp_step.sv =====
module uqfp_step #(
   parameter logic [7:0] FIELD_CAP = 8'd255
) (
   input  uqfp_pkg::parse_state_type cur,
   input  logic [7:0]                in_byte,
   output uqfp_pkg::parse_state_type nxt,
   output logic                      emit,
   output uqfp_pkg::result_type      res
);

   logic [4:0]          hex;
   logic [3:0]          nib;
   uqfp_pkg::kind_type  text_kind;
   logic [8:0]          total;

   assign hex       = uqfp_pkg::hex_nibble(in_byte);
   assign nib       = hex[4] ? 4'd0 : hex[3:0];
   assign text_kind = cur.in_value ? uqfp_pkg::KIND_VALUE : uqfp_pkg::KIND_NAME;
   assign total     = {1'b0, cur.field} + 9'd1;

   always_comb begin
      nxt             = cur;
      emit            = 1'b0;
      res.kind        = text_kind;
      res.data_byte   = 8'd0;
      res.field_index = cur.field;
      res.bad_escape  = 1'b0;
      res.field_total = 9'd0;
      res.last        = 1'b0;

      if (in_byte == uqfp_pkg::CHR_NUL) begin
         // close the query; a cut-short escape still counts the field
         emit           = 1'b1;
         res.kind       = uqfp_pkg::KIND_FEND;
         res.last       = 1'b1;
         res.bad_escape = (cur.phase != uqfp_pkg::ESC_PLAIN);
         if (cur.started || cur.phase != uqfp_pkg::ESC_PLAIN) begin
            res.field_total = total;
         end
         nxt = uqfp_pkg::STATE_RESET;
      end else begin
         unique case (cur.phase) inside
            uqfp_pkg::ESC_PLAIN: begin
               nxt.started = 1'b1;
               if (in_byte == uqfp_pkg::CHR_EQ) begin
                  emit         = 1'b1;
                  res.kind     = uqfp_pkg::KIND_VBEGIN;
                  nxt.in_value = 1'b1;
               end else if (in_byte == uqfp_pkg::CHR_AMP) begin
                  emit         = 1'b1;
                  res.kind     = uqfp_pkg::KIND_FEND;
                  nxt.in_value = 1'b0;
                  if (cur.field < FIELD_CAP) begin
                     nxt.field = cur.field + 8'd1;
                  end
               end else if (in_byte == uqfp_pkg::CHR_PCT) begin
                  nxt.phase       = uqfp_pkg::ESC_HI;
                  nxt.high_nibble = 4'd0;
               end else begin
                  emit          = 1'b1;
                  res.data_byte = in_byte;
               end
            end
            uqfp_pkg::ESC_HI: begin
               nxt.high_nibble = nib;
               nxt.phase       = hex[4] ? uqfp_pkg::ESC_LO_BAD : uqfp_pkg::ESC_LO;
            end
            uqfp_pkg::ESC_LO, uqfp_pkg::ESC_LO_BAD: begin
               emit            = 1'b1;
               res.data_byte   = {cur.high_nibble, nib};
               res.bad_escape  = hex[4] || (cur.phase == uqfp_pkg::ESC_LO_BAD);
               nxt.phase       = uqfp_pkg::ESC_PLAIN;
               nxt.high_nibble = 4'd0;
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

endmodule

// ===== sv/uqfp_out.sv =====
module uqfp_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  uqfp_pkg::result_type push_data,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output uqfp_pkg::result_type rsp_data,
   output logic                 full
);

   uqfp_pkg::result_type head_ff, spare_ff;
   logic [1:0]           count_ff;
   logic                 pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // two-beat queue: head drives the port, spare catches a beat while head is stalled
   always_ff @(posedge clock) begin
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_ff <= spare_ff;
            if (push) begin
               spare_ff <= push_data;
            end
         end else if (push) begin
            head_ff <= push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_ff <= push_data;
         end else begin
            spare_ff <= push_data;
         end
      end
   end

endmodule

// ===== sv/url_query_field_parser_core.sv =====
// A result beat is registered in the result queue before it appears on rsp_*.
// Throughput: one byte per cycle while not stalled; the escape decoder is combinational.
// A two-beat result queue keeps bytes flowing while one result waits under rsp_stall.
// Reset (synchronous, active high) empties the queue and returns the parser to the
// start of a query with field index zero.
module url_query_field_parser_core #(
   parameter int MAX_FIELDS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_field_index,
   output logic       rsp_bad_escape,
   output logic [8:0] rsp_field_total,
   output logic       rsp_last
);

   localparam int         CapInt   = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;
   localparam logic [7:0] FieldCap = 8'(CapInt);

   uqfp_pkg::parse_state_type state_ff, state_in;
   uqfp_pkg::result_type      step_res, out_res;
   logic                      step_emit;
   logic                      accept;
   logic                      full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = full;

   uqfp_step #(
      .FIELD_CAP(FieldCap)
   ) u_step (
      .cur     (state_ff),
      .in_byte (req_in_byte),
      .nxt     (state_in),
      .emit    (step_emit),
      .res     (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uqfp_pkg::STATE_RESET;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   uqfp_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step_emit),
      .push_data (step_res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (out_res),
      .full      (full)
   );

   assign rsp_kind        = out_res.kind;
   assign rsp_data_byte   = out_res.data_byte;
   assign rsp_field_index = out_res.field_index;
   assign rsp_bad_escape  = out_res.bad_escape;
   assign rsp_field_total = out_res.field_total;
   assign rsp_last        = out_res.last;

endmodule

// ===== sv/uqfp_checker.sv =====
module uqfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_field_index,
   input logic [8:0] rsp_field_total,
   input logic       rsp_last
);

   a_last_is_fend: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind == uqfp_pkg::KIND_FEND)
      else $error("closing beat is not a field end");

   a_total_only_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_field_total == 9'd0)
      else $error("field total shown before the query closes");

   a_markers_carry_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == uqfp_pkg::KIND_VBEGIN || rsp_kind == uqfp_pkg::KIND_FEND)
      |-> rsp_data_byte == 8'd0)
      else $error("marker beat carries data");

   a_empty_query_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && rsp_field_total == 9'd0 |-> rsp_field_index == 8'd0)
      else $error("empty query closes with non-zero field index");

   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_data_byte))
      else $error("stalled result beat changed");

endmodule

bind url_query_field_parser_core uqfp_checker u_uqfp_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_kind        (rsp_kind),
   .rsp_data_byte   (rsp_data_byte),
   .rsp_field_index (rsp_field_index),
   .rsp_field_total (rsp_field_total),
   .rsp_last        (rsp_last)
);

// ===== dv/uqfp_decode_check.sv =====
module uqfp_decode_check #(
   parameter int MAX_FIELDS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [1:0] rsp_kind,
   input  logic [7:0] rsp_data_byte,
   input  logic [7:0] rsp_field_index,
   input  logic       rsp_bad_escape,
   input  logic [8:0] rsp_field_total,
   input  logic       rsp_last,
   output int         error_count,
   output int         pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIELD_CAP = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

   uqfp_pkg::esc_type phase;
   logic [3:0]        high;
   logic              in_value;
   logic [7:0]        field;
   logic              started;

   uqfp_pkg::result_type decoded_tokens [$];
   uqfp_pkg::result_type token;
   uqfp_pkg::result_type want;

   // Bit 4 set: not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] b);
      logic [7:0] d;
      d = 8'd0;
      if (b >= "0" && b <= "9") begin
         d = b - 8'h30;
      end else if (b >= "A" && b <= "F") begin
         d = b - 8'h37;
      end else if (b >= "a" && b <= "f") begin
         d = b - 8'h57;
      end else begin
         return 5'h10;
      end
      return {1'b0, d[3:0]};
   endfunction

   function automatic void clear_parse();
      phase    = uqfp_pkg::ESC_PLAIN;
      high     = 4'd0;
      in_value = 1'b0;
      field    = 8'd0;
      started  = 1'b0;
   endfunction

   function automatic void close_query(input logic bad, inout uqfp_pkg::result_type r);
      r.kind        = uqfp_pkg::KIND_FEND;
      r.data_byte   = 8'd0;
      r.bad_escape  = bad;
      r.field_total = started ? {1'b0, field} + 9'd1 : 9'd0;
      r.last        = 1'b1;
      clear_parse();
   endfunction

   // Advance the parser by one byte; returns 1 when the byte yields a result beat
   function automatic logic decode_byte(input logic [7:0] b,
                                        output uqfp_pkg::result_type r);
      logic [4:0] nib;
      r = '0;
      r.field_index = field;
      if (phase != uqfp_pkg::ESC_PLAIN) begin
         if (b == uqfp_pkg::CHR_NUL) begin
            started = 1'b1;
            close_query(1'b1, r);
            return 1'b1;
         end
         nib = hex_value(b);
         if (phase == uqfp_pkg::ESC_HI) begin
            high  = nib[4] ? 4'd0 : nib[3:0];
            phase = nib[4] ? uqfp_pkg::ESC_LO_BAD : uqfp_pkg::ESC_LO;
            return 1'b0;
         end
         r.kind       = in_value ? uqfp_pkg::KIND_VALUE : uqfp_pkg::KIND_NAME;
         r.data_byte  = {high, nib[4] ? 4'd0 : nib[3:0]};
         r.bad_escape = (phase == uqfp_pkg::ESC_LO_BAD) || nib[4];
         phase = uqfp_pkg::ESC_PLAIN;
         high  = 4'd0;
         return 1'b1;
      end
      if (b == uqfp_pkg::CHR_NUL) begin
         close_query(1'b0, r);
         return 1'b1;
      end
      started = 1'b1;
      if (b == uqfp_pkg::CHR_EQ) begin
         in_value = 1'b1;
         r.kind   = uqfp_pkg::KIND_VBEGIN;
         return 1'b1;
      end
      if (b == uqfp_pkg::CHR_AMP) begin
         r.kind = uqfp_pkg::KIND_FEND;
         if (int'(field) < FIELD_CAP) field = field + 8'd1;
         in_value = 1'b0;
         return 1'b1;
      end
      if (b == uqfp_pkg::CHR_PCT) begin
         phase = uqfp_pkg::ESC_HI;
         high  = 4'd0;
         return 1'b0;
      end
      r.kind      = in_value ? uqfp_pkg::KIND_VALUE : uqfp_pkg::KIND_NAME;
      r.data_byte = b;
      return 1'b1;
   endfunction

   initial begin
      error_count = 0;
      pending     = 0;
      clear_parse();
   end

   always @(posedge clock) begin
      if (reset) begin
         decoded_tokens.delete();
         clear_parse();
      end else begin
         // Take the result beat first: a byte never yields a beat on its own edge
         if (rsp_valid && !rsp_stall) begin
            if (decoded_tokens.size() == 0) begin
               $error("result beat with nothing expected: kind %0d data %0h",
                      rsp_kind, rsp_data_byte);
               error_count++;
            end else begin
               want = decoded_tokens.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
                  error_count++;
               end
               if (rsp_data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, got %0h", want.data_byte, rsp_data_byte);
                  error_count++;
               end
               if (rsp_field_index !== want.field_index) begin
                  $error("field_index: expected %0d, got %0d",
                         want.field_index, rsp_field_index);
                  error_count++;
               end
               if (rsp_bad_escape !== want.bad_escape) begin
                  $error("bad_escape: expected %0b, got %0b",
                         want.bad_escape, rsp_bad_escape);
                  error_count++;
               end
               if (rsp_field_total !== want.field_total) begin
                  $error("field_total: expected %0d, got %0d",
                         want.field_total, rsp_field_total);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_last);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_byte(req_in_byte, token)) decoded_tokens.push_back(token);
         end
      end
      pending = decoded_tokens.size();
   end

endmodule

// ===== dv/url_query_field_parser_core_test.sv =====
module url_query_field_parser_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_field_index;
   logic       rsp_bad_escape;
   logic [8:0] rsp_field_total;
   logic       rsp_last;

   int error_count;
   int pending;
   int send_idle_pct;
   int recv_idle_pct;
   int bytes_sent;
   int hold_left;
   bit hold_request;

   logic [7:0] directed [0:28];

   url_query_field_parser_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_field_index (rsp_field_index),
      .rsp_bad_escape  (rsp_bad_escape),
      .rsp_field_total (rsp_field_total),
      .rsp_last        (rsp_last)
   );

   uqfp_decode_check u_decode_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_field_index (rsp_field_index),
      .rsp_bad_escape  (rsp_bad_escape),
      .rsp_field_total (rsp_field_total),
      .rsp_last        (rsp_last),
      .error_count     (error_count),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Receiver: random stall, or a long hold-off when asked for
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // Entered and left at a falling edge
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending == 0);
      @(negedge clock);
   endtask

   function automatic logic [7:0] escape_digit();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      n    = $urandom_range(0, 21);
      if (pick < 80) begin
         if (n < 10) return 8'h30 + 8'(n);
         if (n < 16) return 8'h41 + 8'(n - 10);
         return 8'h61 + 8'(n - 16);
      end
      if (pick < 97) return 8'($urandom_range(1, 255));
      return uqfp_pkg::CHR_NUL;
   endfunction

   task automatic send_random_query();
      int len;
      int pick;
      len = $urandom_range(0, 24);
      if ($urandom_range(0, 19) == 0) begin
         // noise, zero bytes included
         repeat (8) send_byte(8'($urandom_range(0, 255)));
      end else begin
         for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_byte(8'($urandom_range(1, 255)));
            end else if (pick < 52) begin
               send_byte(uqfp_pkg::CHR_EQ);
            end else if (pick < 64) begin
               send_byte(uqfp_pkg::CHR_AMP);
            end else if (pick < 86) begin
               send_byte(uqfp_pkg::CHR_PCT);
               // cut the escape short now and then
               if ($urandom_range(0, 49) == 0) begin
                  send_byte(uqfp_pkg::CHR_NUL);
                  return;
               end
               send_byte(escape_digit());
               send_byte(escape_digit());
            end else begin
               send_byte(8'h61 + 8'($urandom_range(0, 25)));
            end
         end
      end
      send_byte(uqfp_pkg::CHR_NUL);
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_in_byte   = 8'd0;
      send_idle_pct = 30;
      recv_idle_pct = 58;
      bytes_sent    = 0;
      hold_request  = 1'b0;
      directed = '{uqfp_pkg::CHR_NUL,
                   8'h78, uqfp_pkg::CHR_EQ, 8'hFF, uqfp_pkg::CHR_EQ, 8'h01,
                   uqfp_pkg::CHR_AMP,
                   uqfp_pkg::CHR_PCT, 8'h32, 8'h36, uqfp_pkg::CHR_PCT, 8'h33, 8'h44,
                   uqfp_pkg::CHR_EQ,
                   uqfp_pkg::CHR_PCT, 8'h67, 8'h37, uqfp_pkg::CHR_PCT, 8'h33, 8'h7A,
                   uqfp_pkg::CHR_NUL,
                   uqfp_pkg::CHR_PCT, uqfp_pkg::CHR_NUL,
                   uqfp_pkg::CHR_PCT, 8'h61, uqfp_pkg::CHR_NUL,
                   uqfp_pkg::CHR_PCT, 8'h5A, uqfp_pkg::CHR_NUL};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) send_byte(directed[i]);
      while (bytes_sent < 350) send_random_query();
      drain();

      send_idle_pct = 58;
      recv_idle_pct = 30;
      while (bytes_sent < 700) send_random_query();
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      // hold the receiver off and keep offering bytes until the input stalls
      hold_request = 1'b1;
      repeat (60) send_byte(8'h61 + 8'($urandom_range(0, 25)));
      // run the field index into its limit
      send_byte(8'h6B);
      repeat (300) send_byte(uqfp_pkg::CHR_AMP);
      send_byte(uqfp_pkg::CHR_EQ);
      send_byte(uqfp_pkg::CHR_PCT);
      send_byte(8'h34);
      send_byte(8'h31);
      send_byte(uqfp_pkg::CHR_NUL);
      while (bytes_sent < 1200) send_random_query();

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
